>>> rtl/core/clsr_pkg.sv
// Package for the combined multiplicative generator with shuffle table.
// Holds generator constants, reciprocals and sequencer enum types.
// No dependencies.
package clsr_pkg;

  localparam int TABLE_SIZE_DEF = 32;

  localparam logic [31:0] MOD_A  = 32'd2147483563;
  localparam logic [31:0] MOD_B  = 32'd2147483399;
  localparam logic [31:0] MUL_A  = 32'd40014;
  localparam logic [31:0] MUL_B  = 32'd40692;
  localparam logic [31:0] QUO_A  = 32'd53668;
  localparam logic [31:0] QUO_B  = 32'd52774;
  localparam logic [31:0] REM_A  = 32'd12211;
  localparam logic [31:0] REM_B  = 32'd3791;
  localparam logic [30:0] SEED_B = 31'd123456789;

  localparam int RECIP_SHIFT = 47;
  localparam int QUO_W       = 16;

  localparam logic [31:0] RECIP_A = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_A));
  localparam logic [31:0] RECIP_B = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_B));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_EST,
    ST_DIV_MUL,
    ST_DIV_REM,
    ST_DIV_FIX,
    ST_SCH_MUL_A,
    ST_SCH_MUL_R,
    ST_SCH_SUB,
    ST_SCH_WB,
    ST_TAB_READ,
    ST_TAB_DIFF,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_WARM,
    PH_GEN_A,
    PH_GEN_B,
    PH_INDEX
  } phase_t;

endpackage

>>> rtl/core/combined_lcg_shuffle_rng_core.sv
// Combined two-generator random source with shuffle table, one shared multiplier.
// A draw runs a step of generator A, one of generator B and the table-index
// division, then reads the shuffle table and registers the output; start is
// accepted again in the cycle in which done is high. A reseed first runs warm-up
// steps of generator A that fill the shuffle table; start is taken only in idle.
// Reset: generators, shuffle output and table valid bits; receiver cannot stall.
module combined_lcg_shuffle_rng_core #(
  parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [30:0] seed_value,
  output logic        done,
  output logic [30:0] random_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 8);
  localparam int QW    = clsr_pkg::QUO_W;
  localparam int RS    = clsr_pkg::RECIP_SHIFT;

  localparam logic [31:0] BUCKET =
    32'(64'd1 + 64'(clsr_pkg::MOD_A - 32'd1) / 64'(TABLE_SIZE));
  localparam logic [31:0] RECIP_IDX = 32'((64'd1 << RS) / 64'(BUCKET));
  localparam logic [QW-1:0] IDX_MAX = QW'(TABLE_SIZE - 1);

  clsr_pkg::state_t state, state_next;
  clsr_pkg::phase_t phase;

  logic [30:0]        fg;
  logic [30:0]        sg;
  logic [30:0]        shuf_out;
  logic [CNT_W-1:0]   cnt;
  logic [30:0]        x;
  logic [63:0]        prod;
  logic [QW-1:0]      quo;
  logic [31:0]        rem;
  logic [31:0]        p1;
  logic signed [32:0] diff;
  logic signed [32:0] odiff;
  logic [IDX_W-1:0]   idx;

  logic [30:0]           shuf_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] ent_valid;
  logic [30:0]           rd_data;
  logic                  rd_hit;

  logic [31:0]      mul_x, mul_y;
  logic [63:0]      mul_p;
  logic             sel_a;
  logic [31:0]      dconst, rconst, mconst, qrem, modc;
  logic [32:0]      wb_sum;
  logic [30:0]      gen_res;
  logic [IDX_W-1:0] idx_clamp;
  logic [30:0]      tab_val;
  logic [32:0]      osum;
  logic [30:0]      seed_eff;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [30:0]      wr_data;

  assign busy     = (state != clsr_pkg::ST_IDLE);
  assign sel_a    = (phase != clsr_pkg::PH_GEN_B);
  assign dconst   = (phase == clsr_pkg::PH_INDEX) ? BUCKET :
                    (sel_a ? clsr_pkg::QUO_A : clsr_pkg::QUO_B);
  assign rconst   = (phase == clsr_pkg::PH_INDEX) ? RECIP_IDX :
                    (sel_a ? clsr_pkg::RECIP_A : clsr_pkg::RECIP_B);
  assign mconst   = sel_a ? clsr_pkg::MUL_A : clsr_pkg::MUL_B;
  assign qrem     = sel_a ? clsr_pkg::REM_A : clsr_pkg::REM_B;
  assign modc     = sel_a ? clsr_pkg::MOD_A : clsr_pkg::MOD_B;
  assign mul_p    = mul_x * mul_y;
  assign wb_sum   = diff[32] ? 33'(diff + $signed({1'b0, modc})) : 33'(diff);
  assign gen_res  = wb_sum[30:0];
  assign idx_clamp = (quo > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : quo[IDX_W-1:0];
  assign tab_val  = rd_hit ? rd_data : 31'd0;
  assign osum     = (odiff < 33'sd1) ? 33'(odiff + $signed({1'b0, clsr_pkg::MOD_A - 32'd1}))
                                     : 33'(odiff);
  assign seed_eff = (seed_value == 31'd0) ? 31'd1 : seed_value;

  always_comb begin
    state_next = state;
    unique case (state)
      clsr_pkg::ST_IDLE:      if (start) state_next = clsr_pkg::ST_DIV_EST;
      clsr_pkg::ST_DIV_EST:   state_next = clsr_pkg::ST_DIV_MUL;
      clsr_pkg::ST_DIV_MUL:   state_next = clsr_pkg::ST_DIV_REM;
      clsr_pkg::ST_DIV_REM:   state_next = clsr_pkg::ST_DIV_FIX;
      clsr_pkg::ST_DIV_FIX:   state_next = (phase == clsr_pkg::PH_INDEX) ?
                                           clsr_pkg::ST_TAB_READ : clsr_pkg::ST_SCH_MUL_A;
      clsr_pkg::ST_SCH_MUL_A: state_next = clsr_pkg::ST_SCH_MUL_R;
      clsr_pkg::ST_SCH_MUL_R: state_next = clsr_pkg::ST_SCH_SUB;
      clsr_pkg::ST_SCH_SUB:   state_next = clsr_pkg::ST_SCH_WB;
      clsr_pkg::ST_SCH_WB:    state_next = clsr_pkg::ST_DIV_EST;
      clsr_pkg::ST_TAB_READ:  state_next = clsr_pkg::ST_TAB_DIFF;
      clsr_pkg::ST_TAB_DIFF:  state_next = clsr_pkg::ST_OUT;
      clsr_pkg::ST_OUT:       state_next = clsr_pkg::ST_IDLE;
      default:                state_next = clsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_x   = 32'd0;
    mul_y   = 32'd0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = fg;
    unique case (state)
      clsr_pkg::ST_DIV_EST: begin
        mul_x = {1'b0, x};
        mul_y = rconst;
      end
      clsr_pkg::ST_DIV_MUL: begin
        mul_x = 32'(prod[RS +: QW]);
        mul_y = dconst;
      end
      clsr_pkg::ST_SCH_MUL_A: begin
        mul_x = rem;
        mul_y = mconst;
      end
      clsr_pkg::ST_SCH_MUL_R: begin
        mul_x = 32'(quo);
        mul_y = qrem;
      end
      clsr_pkg::ST_SCH_WB: begin
        wr_en   = (phase == clsr_pkg::PH_WARM) && (cnt < CNT_W'(TABLE_SIZE));
        wr_addr = cnt[IDX_W-1:0];
        wr_data = gen_res;
      end
      clsr_pkg::ST_OUT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = fg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      shuf_mem[wr_addr] <= wr_data;
    end
    if (state == clsr_pkg::ST_TAB_READ) begin
      rd_data <= shuf_mem[idx_clamp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
      if (state == clsr_pkg::ST_TAB_READ) begin
        rd_hit <= ent_valid[idx_clamp];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      clsr_pkg::ST_DIV_EST, clsr_pkg::ST_SCH_MUL_A: prod <= mul_p;
      clsr_pkg::ST_DIV_MUL: begin
        prod <= mul_p;
        quo  <= prod[RS +: QW];
      end
      clsr_pkg::ST_DIV_REM: rem <= {1'b0, x} - prod[31:0];
      clsr_pkg::ST_DIV_FIX: begin
        if (rem >= dconst) begin
          quo <= quo + QW'(1);
          rem <= rem - dconst;
        end
      end
      clsr_pkg::ST_SCH_MUL_R: begin
        p1   <= prod[31:0];
        prod <= mul_p;
      end
      clsr_pkg::ST_SCH_SUB:  diff  <= $signed({1'b0, p1}) - $signed({1'b0, prod[31:0]});
      clsr_pkg::ST_TAB_READ: idx   <= idx_clamp;
      clsr_pkg::ST_TAB_DIFF: odiff <= $signed({2'b0, tab_val}) - $signed({2'b0, sg});
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clsr_pkg::ST_IDLE;
      phase        <= clsr_pkg::PH_GEN_A;
      cnt          <= '0;
      fg           <= 31'd1;
      sg           <= clsr_pkg::SEED_B;
      shuf_out     <= 31'd0;
      done         <= 1'b0;
      random_value <= 31'd0;
      x            <= 31'd0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        clsr_pkg::ST_IDLE: begin
          if (start) begin
            if (op) begin
              fg    <= seed_eff;
              sg    <= seed_eff;
              x     <= seed_eff;
              cnt   <= CNT_W'(TABLE_SIZE + 7);
              phase <= clsr_pkg::PH_WARM;
            end else begin
              x     <= fg;
              phase <= clsr_pkg::PH_GEN_A;
            end
          end
        end
        clsr_pkg::ST_SCH_WB: begin
          unique case (phase)
            clsr_pkg::PH_WARM: begin
              fg <= gen_res;
              x  <= gen_res;
              if (cnt == '0) begin
                shuf_out <= gen_res;
                phase    <= clsr_pkg::PH_GEN_A;
              end else begin
                cnt <= cnt - CNT_W'(1);
              end
            end
            clsr_pkg::PH_GEN_A: begin
              fg    <= gen_res;
              x     <= sg;
              phase <= clsr_pkg::PH_GEN_B;
            end
            clsr_pkg::PH_GEN_B: begin
              sg    <= gen_res;
              x     <= shuf_out;
              phase <= clsr_pkg::PH_INDEX;
            end
            default: begin
            end
          endcase
        end
        clsr_pkg::ST_OUT: begin
          shuf_out     <= osum[30:0];
          random_value <= osum[30:0];
          done         <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
